// File: rtl/core/diatonic_quantize_chord_build_unit_macros.svh
// ---------------------------------------------------------------------------
// diatonic quantize chord build unit: assertion macros
// shared concurrent assertion forms, clocked on clk_i, off during reset
// ---------------------------------------------------------------------------
`ifndef DIATONIC_QUANTIZE_CHORD_BUILD_UNIT_MACROS_SVH
`define DIATONIC_QUANTIZE_CHORD_BUILD_UNIT_MACROS_SVH

// same-cycle implication
`define DQCB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dqcb same-cycle check failed");

// next-cycle implication
`define DQCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dqcb next-cycle check failed");

`endif

// File: rtl/core/dqcb_pkg.sv
// ---------------------------------------------------------------------------
// dqcb_pkg
// types, scale tables and lookup helpers for the chord build unit
// ---------------------------------------------------------------------------
package dqcb_pkg;

  localparam int MaxChordTones = 7;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_ROOT    = 2'd0;
  localparam logic [1:0] REG_MODE_SELECT = 2'd1;
  localparam logic [1:0] REG_CHORD_SIZE  = 2'd2;

  // semitone offset of each degree above the tonic, one row per mode
  localparam logic [3:0] SCALE_OFFS [7][7] = '{
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
    '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11},
    '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10},
    '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10},
    '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10}
  };

  // degree offsets of the chord tones: root, third and fifth, repeated up the octaves
  localparam logic [4:0] THIRD_STACK [MaxChordTones] = '{
    5'd0, 5'd2, 5'd4, 5'd7, 5'd9, 5'd11, 5'd14
  };

  // effective configuration, already folded into range
  typedef struct packed {
    logic [3:0] key;
    logic [2:0] mode;
    logic [2:0] tones;
  } dqcb_cfg_t;

  // one press as handed from front to back
  typedef struct packed {
    logic [6:0] held_degree;
    logic       out_of_key;
  } dqcb_entry_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] degree;
  } dqcb_find_t;

  // degree within the mode whose offset equals the pitch class
  function automatic dqcb_find_t scale_find(input logic [2:0] mode, input logic [3:0] pc);
    dqcb_find_t res;
    res = '0;
    for (int d = 0; d < 7; d++) begin
      if (SCALE_OFFS[mode][d] == pc) begin
        res.hit    = 1'b1;
        res.degree = 3'(d);
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/diatonic_quantize_chord_build_unit.sv
// ---------------------------------------------------------------------------
// diatonic_quantize_chord_build_unit
// diatonic scale quantizer with a stacked-third chord builder
// ---------------------------------------------------------------------------
// an accepted press is registered in the queue, and its first chord tone is then
//   registered in the output register
// throughput: one tone per cycle while the output does not stall; a press gives
//   chord_size tones (1..7) on the output port; the back-end tone walker sets the rate
// a two-entry queue lets the front take presses while tones drain
// reset: asynchronous, active low; held degree 0, key C, Ionian, four tones
// ---------------------------------------------------------------------------
`include "diatonic_quantize_chord_build_unit_macros.svh"

module diatonic_quantize_chord_build_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [3:0]        cfg_data_i,
  // press channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic signed [7:0] semitone_i,
  // chord tone channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [8:0] chord_semitone_o,
  output logic [2:0]        tone_index_o,
  output logic signed [6:0] held_degree_o,
  output logic              out_of_key_o,
  output logic              last_tone_o
);
  import dqcb_pkg::*;

  // raw configuration registers
  logic [3:0] key_q;
  logic [2:0] mode_q;
  logic [2:0] size_q;

  dqcb_cfg_t   cfg;
  logic        in_accept;
  logic        fifo_full;
  logic        fifo_valid;
  logic        fifo_pop;
  dqcb_entry_t front_entry;
  dqcb_entry_t back_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= 4'd0;
      mode_q <= 3'd0;
      size_q <= 3'd4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_ROOT:    key_q  <= cfg_data_i;
        REG_MODE_SELECT: mode_q <= cfg_data_i[2:0];
        REG_CHORD_SIZE:  size_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // fold out-of-range settings: keys above B wrap, mode 7 is Ionian,
  // a zero chord size gives a single tone
  always_comb begin
    cfg.key   = (key_q >= 4'd12) ? key_q - 4'd12 : key_q;
    cfg.mode  = (mode_q == 3'd7) ? 3'd0 : mode_q;
    cfg.tones = (size_q == 3'd0) ? 3'd1 : size_q;
  end

  // the front only stalls when the queue is full
  assign in_stall_o = fifo_full;
  assign in_accept  = in_valid_i && !fifo_full;

  // front: saturate, classify in or out of key, update the held degree
  dqcb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .accept_i   (in_accept),
    .semitone_i (semitone_i),
    .entry_o    (front_entry)
  );

  // queue of classified presses
  dqcb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_data_i (front_entry),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .pop_data_o  (back_entry)
  );

  // back: one chord tone per cycle into the output register, while the output does not stall
  dqcb_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .entry_valid_i    (fifo_valid),
    .entry_i          (back_entry),
    .pop_o            (fifo_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .chord_semitone_o (chord_semitone_o),
    .tone_index_o     (tone_index_o),
    .held_degree_o    (held_degree_o),
    .out_of_key_o     (out_of_key_o),
    .last_tone_o      (last_tone_o)
  );

  // the final tone of a press has the index one below the configured chord size
  `DQCB_ASSERT_NOW(a_last_at_size, out_valid_o && last_tone_o,
                   tone_index_o == cfg.tones - 3'd1)

  // a taken tone that is not the last is followed at once by the next one
  `DQCB_ASSERT_NEXT(a_tone_follows, out_valid_o && !out_stall_i && !last_tone_o,
                    out_valid_o && (tone_index_o == $past(tone_index_o) + 3'd1))

  // a press taken into an empty pipe reaches the back on the next cycle
  `DQCB_ASSERT_NEXT(a_queue_fills, in_valid_i && !in_stall_o, fifo_valid)

endmodule

// File: rtl/core/dqcb_front.sv
// ---------------------------------------------------------------------------
// dqcb_front
// saturates a press, finds its scale degree and keeps the held degree
// ---------------------------------------------------------------------------
module dqcb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqcb_pkg::dqcb_cfg_t cfg_i,
  input  logic               accept_i,
  input  logic signed [7:0]  semitone_i,
  output dqcb_pkg::dqcb_entry_t entry_o
);
  import dqcb_pkg::*;

  logic signed [7:0] sat;
  logic signed [8:0] v_s;
  logic [7:0]        v;
  logic [15:0]       prod;
  logic [4:0]        q;
  logic [7:0]        r_full;
  logic [3:0]        pc;
  dqcb_find_t        f_hit;
  logic [2:0]        d_sel;
  logic [7:0]        t;
  logic [7:0]        deg;
  logic [6:0]        held_q, held_d;

  always_comb begin
    if (semitone_i < -8'sd96) begin
      sat = -8'sd96;
    end else if (semitone_i > 8'sd95) begin
      sat = 8'sd95;
    end else begin
      sat = semitone_i;
    end
    // shifted so the value is positive: 1..203
    v_s    = 9'(sat) + 9'sd108 - $signed({5'b0, cfg_i.key});
    v      = v_s[7:0];
    // divide by twelve through the reciprocal 171/2048
    prod   = 16'(v) * 16'd171;
    q      = prod[15:11];
    r_full = v - 8'(q) * 8'd12;
    pc     = r_full[3:0];
    f_hit  = scale_find(cfg_i.mode, pc);
    // an out-of-key press keeps the held degree, so only a hit needs a degree
    d_sel  = f_hit.degree;
    t      = 8'(q) * 8'd7 + {5'b0, d_sel};
    deg    = t - 8'd63;
    held_d = (accept_i && f_hit.hit) ? deg[6:0] : held_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else begin
      held_q <= held_d;
    end
  end

  assign entry_o.held_degree = f_hit.hit ? deg[6:0] : held_q;
  assign entry_o.out_of_key  = ~f_hit.hit;

endmodule

// File: rtl/core/dqcb_fifo.sv
// ---------------------------------------------------------------------------
// dqcb_fifo
// two-entry queue between the front and the back
// ---------------------------------------------------------------------------
module dqcb_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  dqcb_pkg::dqcb_entry_t push_data_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output dqcb_pkg::dqcb_entry_t pop_data_o
);
  import dqcb_pkg::*;

  dqcb_entry_t slot0_q;
  dqcb_entry_t slot1_q;
  logic        wr_q, wr_d;
  logic        rd_q, rd_d;
  logic [1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !wr_q) begin
      slot0_q <= push_data_i;
    end
    if (push_i && wr_q) begin
      slot1_q <= push_data_i;
    end
  end

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = rd_q ? slot1_q : slot0_q;

endmodule

// File: rtl/core/dqcb_back.sv
// ---------------------------------------------------------------------------
// dqcb_back
// walks the chord tones of the queued press, one tone per cycle unless the output stalls
// ---------------------------------------------------------------------------
module dqcb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dqcb_pkg::dqcb_cfg_t   cfg_i,
  input  logic                  entry_valid_i,
  input  dqcb_pkg::dqcb_entry_t entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [8:0]     chord_semitone_o,
  output logic [2:0]            tone_index_o,
  output logic signed [6:0]     held_degree_o,
  output logic                  out_of_key_o,
  output logic                  last_tone_o
);
  import dqcb_pkg::*;

  logic [2:0]  cnt_q, cnt_d;
  logic        load;
  logic        last;
  logic [7:0]  deg;
  logic [7:0]  x;
  logic [15:0] prod;
  logic [4:0]  q;
  logic [7:0]  r_full;
  logic [9:0]  s;

  logic       valid_q, valid_d;
  logic [8:0] semi_q;
  logic [2:0] idx_q;
  logic [6:0] held_q;
  logic       ook_q;
  logic       last_q;

  always_comb begin
    load   = entry_valid_i && (!valid_q || !out_stall_i);
    last   = (cnt_q == cfg_i.tones - 3'd1);
    deg    = {entry_i.held_degree[6], entry_i.held_degree} + {3'b0, THIRD_STACK[cnt_q]};
    // positive by construction: 8..139
    x      = deg + 8'd70;
    // divide by seven through the reciprocal 147/1024
    prod   = 16'(x) * 16'd147;
    q      = prod[14:10];
    r_full = x - 8'(q) * 8'd7;
    s      = {6'b0, cfg_i.key} + 10'(q) * 10'd12
           + {6'b0, SCALE_OFFS[cfg_i.mode][r_full[2:0]]} - 10'd120;
    cnt_d  = cnt_q;
    if (load) begin
      cnt_d = last ? 3'd0 : cnt_q + 3'd1;
    end
    valid_d = load ? 1'b1 : (out_stall_i ? valid_q : 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      semi_q <= s[8:0];
      idx_q  <= cnt_q;
      held_q <= entry_i.held_degree;
      ook_q  <= entry_i.out_of_key;
      last_q <= last;
    end
  end

  assign pop_o            = load && last;
  assign out_valid_o      = valid_q;
  assign chord_semitone_o = $signed(semi_q);
  assign tone_index_o     = idx_q;
  assign held_degree_o    = $signed(held_q);
  assign out_of_key_o     = ook_q;
  assign last_tone_o      = last_q;

endmodule
